/* hdl/clnbs_pkg.sv */
// Shared types and constants for the character LCD nibble bus sequencer.
package clnbs_pkg;

    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_CHAR   = 2'd1,
        OP_SETPOS = 2'd2,
        OP_INIT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SHOW
    } t_state;

    typedef enum logic [1:0] {
        REG_BUSY_WAIT    = 2'd0,
        REG_FUNCTION_SET = 2'd1,
        REG_ENTRY_MODE   = 2'd2
    } t_reg_idx;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic load;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic evt_last;
    } t_status;

    localparam logic [7:0] BUSY_WAIT_RST    = 8'd75;
    localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
    localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;

    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [6:0] ROW1_OFFSET     = 7'h40;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;
    localparam logic [7:0] WAIT_PWR  = 8'd15;
    localparam logic [7:0] WAIT_WAKE = 8'd5;
    localparam logic [7:0] WAIT_LONG = 8'd20;
    localparam logic [7:0] WAIT_CMD  = 8'd1;

    localparam logic [3:0] INIT_FIRST_BYTE = 4'd5;
    localparam logic [3:0] INIT_LAST_EVT   = 4'd14;

endpackage

/* hdl/clnbs_ctrl.sv */
// Controller state machine: request capture and event sequencing.
module clnbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  clnbs_pkg::t_status i_status,
    output clnbs_pkg::t_cmd   o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    clnbs_pkg::t_state r_state;
    clnbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clnbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            clnbs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = clnbs_pkg::ST_LOAD;
                end
            end
            clnbs_pkg::ST_LOAD: begin
                n_state = clnbs_pkg::ST_SHOW;
            end
            clnbs_pkg::ST_SHOW: begin
                if (!i_out_stall && i_status.evt_last) begin
                    n_state = clnbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = clnbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            clnbs_pkg::ST_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.capture  = i_in_valid;
            end
            clnbs_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            clnbs_pkg::ST_SHOW: begin
                o_out_valid = 1'b1;
                // The next event replaces the shown one in the cycle it is taken.
                o_cmd.load  = !i_out_stall && !i_status.evt_last;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* hdl/clnbs_dp.sv */
// Datapath: settings, captured request, event counter and output register.
module clnbs_dp #(
    parameter int ROW_LENGTH = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clnbs_pkg::t_cmd    i_cmd,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_value,
    input  logic [1:0]         i_row,
    input  logic [4:0]         i_column,
    output clnbs_pkg::t_status o_status,
    output logic               o_register_select,
    output logic               o_strobe_res,
    output logic [3:0]         o_nibble,
    output logic [7:0]         o_wait_after,
    output logic               o_last
);

    localparam logic [6:0] ROW2_OFFSET = 7'(ROW_LENGTH);
    localparam logic [6:0] ROW3_OFFSET = 7'(64 + ROW_LENGTH);

    logic [7:0]   r_busy_wait;
    logic [7:0]   r_function_set;
    logic [7:0]   r_entry_mode;
    clnbs_pkg::t_op r_op;
    logic [7:0]   r_byte;
    logic [3:0]   r_idx;
    logic         r_rs;
    logic         r_strobe;
    logic [3:0]   r_nib;
    logic [7:0]   r_wait;
    logic         r_last;

    clnbs_pkg::t_op in_op;
    logic [6:0]   row_offset;
    logic [6:0]   addr_sum;
    logic [7:0]   cap_byte;
    logic         n_rs;
    logic         n_strobe;
    logic [3:0]   n_nib;
    logic [7:0]   n_wait;
    logic         n_last;
    logic [3:0]   init_pos;
    logic [7:0]   init_byte;

    assign in_op = clnbs_pkg::t_op'(i_operation);

    always_comb begin
        case (i_row)
            2'd1:    row_offset = clnbs_pkg::ROW1_OFFSET;
            2'd2:    row_offset = ROW2_OFFSET;
            2'd3:    row_offset = ROW3_OFFSET;
            default: row_offset = 7'd0;
        endcase
        // The DDRAM address is seven bits wide and wraps.
        addr_sum = row_offset + {2'b00, i_column};
        cap_byte = (in_op == clnbs_pkg::OP_SETPOS) ? {1'b1, addr_sum} : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_wait    <= clnbs_pkg::BUSY_WAIT_RST;
            r_function_set <= clnbs_pkg::FUNCTION_SET_RST;
            r_entry_mode   <= clnbs_pkg::ENTRY_MODE_RST;
        end else if (i_cfg_we) begin
            case (clnbs_pkg::t_reg_idx'(i_cfg_index))
                clnbs_pkg::REG_BUSY_WAIT:    r_busy_wait    <= i_cfg_data;
                clnbs_pkg::REG_FUNCTION_SET: r_function_set <= i_cfg_data;
                clnbs_pkg::REG_ENTRY_MODE:   r_entry_mode   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Event generator for the current position in the run.
    always_comb begin
        init_pos = r_idx - clnbs_pkg::INIT_FIRST_BYTE;
        case (init_pos[3:1])
            3'd0:    init_byte = r_function_set;
            3'd1:    init_byte = clnbs_pkg::CMD_DISPLAY_OFF;
            3'd2:    init_byte = clnbs_pkg::CMD_CLEAR;
            3'd3:    init_byte = clnbs_pkg::CMD_DISPLAY_ON;
            default: init_byte = r_entry_mode;
        endcase
        n_rs     = 1'b0;
        n_strobe = 1'b1;
        n_nib    = 4'h0;
        n_wait   = 8'd0;
        n_last   = 1'b0;
        if (r_op == clnbs_pkg::OP_INIT) begin
            case (r_idx) inside
                4'd0: begin
                    n_strobe = 1'b0;
                    n_wait   = clnbs_pkg::WAIT_PWR;
                end
                [4'd1:4'd3]: begin
                    n_nib  = clnbs_pkg::NIB_WAKE;
                    n_wait = clnbs_pkg::WAIT_WAKE;
                end
                4'd4: begin
                    n_nib  = clnbs_pkg::NIB_4BIT;
                    n_wait = clnbs_pkg::WAIT_LONG;
                end
                default: begin
                    if (!init_pos[0]) begin
                        n_nib = init_byte[7:4];
                    end else begin
                        n_nib  = init_byte[3:0];
                        n_wait = (init_pos[3:1] == 3'd2) ? clnbs_pkg::WAIT_LONG
                                                         : clnbs_pkg::WAIT_CMD;
                    end
                    n_last = (r_idx == clnbs_pkg::INIT_LAST_EVT);
                end
            endcase
        end else begin
            n_rs = (r_op == clnbs_pkg::OP_CHAR);
            if (r_idx[0] == 1'b0) begin
                n_nib = r_byte[7:4];
            end else begin
                n_nib  = r_byte[3:0];
                n_wait = r_busy_wait;
                n_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
        end else if (i_cmd.capture) begin
            r_idx <= 4'd0;
        end else if (i_cmd.load) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= in_op;
            r_byte <= cap_byte;
        end
        if (i_cmd.load) begin
            r_rs     <= n_rs;
            r_strobe <= n_strobe;
            r_nib    <= n_nib;
            r_wait   <= n_wait;
            r_last   <= n_last;
        end
    end

    assign o_status.evt_last = r_last;
    assign o_register_select = r_rs;
    assign o_strobe_res      = r_strobe;
    assign o_nibble          = r_nib;
    assign o_wait_after      = r_wait;
    assign o_last            = r_last;

endmodule

/* hdl/char_lcd_nibble_bus_sequencer.sv */
// Top level of the character LCD nibble bus sequencer.
//
//   Channel  Direction  Handshake              Payload
//   in       into       i_in_valid/o_in_stall  operation, value, row, column
//   out      out of     o_out_valid/i_out_stall register_select, strobe_res,
//                                              nibble, wait_after, last
//   cfg      into       i_cfg_we               i_cfg_index, i_cfg_data
//
// One request is taken at a time. Capturing the request leads to a load state that
// fills the output register with the first event, which is then shown; each further
// event is loaded into the output register as the previous one transfers. A byte
// write is a run of two events, initialisation a run of fifteen.
// Synchronous reset returns to idle and restores the three settings.
// An output stall holds the shown event; the request side stalls until the
// final event of a run has transferred.
module char_lcd_nibble_bus_sequencer #(
    parameter int ROW_LENGTH = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_value,
    input  logic [1:0] i_row,
    input  logic [4:0] i_column,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_register_select,
    output logic       o_strobe_res,
    output logic [3:0] o_nibble,
    output logic [7:0] o_wait_after,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    clnbs_pkg::t_cmd    cmd;
    clnbs_pkg::t_status status;

    clnbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    clnbs_dp #(
        .ROW_LENGTH (ROW_LENGTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_value           (i_value),
        .i_row             (i_row),
        .i_column          (i_column),
        .o_status          (status),
        .o_register_select (o_register_select),
        .o_strobe_res      (o_strobe_res),
        .o_nibble          (o_nibble),
        .o_wait_after      (o_wait_after),
        .o_last            (o_last)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("output event shown while requests are being taken");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_out_valid)
        else $error("events continue after the final transfer of a run");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request side not stalled after a request transfer");
`endif

endmodule
